### rtl/imh_pkg.sv
// Shared widths and register indexes of the invertible hash block.
package imh_pkg;

    localparam int unsigned TS_W    = 33;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned WIDE_W  = 97;
    localparam int unsigned PROD_W  = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_SIZE   = 4'd0,
        REG_PRIME        = 4'd1,
        REG_MULTIPLIER   = 4'd2,
        REG_INVERSE      = 4'd3
    } cfg_reg_t;

    localparam logic MODE_HASH    = 1'b0;
    localparam logic MODE_RECOVER = 1'b1;

endpackage

### rtl/imh_div_cell.sv
// One restoring-division step: shift in a dividend bit, subtract when it fits.
module imh_div_cell #(
    parameter int unsigned N = 64,
    parameter int unsigned W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  logic [W-1:0] divisor,
    input  logic         v_in,
    input  logic         sb_in,
    input  logic [W-1:0] rem_in,
    input  logic [N-1:0] dat_in,
    output logic         v_out,
    output logic         sb_out,
    output logic [W-1:0] rem_out,
    output logic [N-1:0] dat_out
);

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;
    logic         v_reg;
    logic         sb_reg;
    logic [W-1:0] rem_reg;
    logic [N-1:0] dat_reg;

    always_comb begin
        trial = {rem_in, dat_in[N-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ce) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sb_reg  <= sb_in;
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            dat_reg <= {dat_in[N-2:0], fits};
        end
    end

    assign v_out   = v_reg;
    assign sb_out  = sb_reg;
    assign rem_out = rem_reg;
    assign dat_out = dat_reg;

endmodule

### rtl/imh_div_chain.sv
// Row of N division cells: remainder and quotient of an N-bit dividend.
module imh_div_chain #(
    parameter int unsigned N = 64,
    parameter int unsigned W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  logic [W-1:0] divisor,
    input  logic         v_in,
    input  logic         sb_in,
    input  logic [N-1:0] dividend,
    output logic         v_out,
    output logic         sb_out,
    output logic [W-1:0] rem_out,
    output logic [N-1:0] quo_out
);

    logic         v_w   [0:N];
    logic         sb_w  [0:N];
    logic [W-1:0] rem_w [0:N];
    logic [N-1:0] dat_w [0:N];

    assign v_w[0]   = v_in;
    assign sb_w[0]  = sb_in;
    assign rem_w[0] = '0;
    assign dat_w[0] = dividend;

    for (genvar i = 0; i < N; i++) begin : g_cell
        imh_div_cell #(.N(N), .W(W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .divisor (divisor),
            .v_in    (v_w[i]),
            .sb_in   (sb_w[i]),
            .rem_in  (rem_w[i]),
            .dat_in  (dat_w[i]),
            .v_out   (v_w[i+1]),
            .sb_out  (sb_w[i+1]),
            .rem_out (rem_w[i+1]),
            .dat_out (dat_w[i+1])
        );
    end

    assign v_out   = v_w[N];
    assign sb_out  = sb_w[N];
    assign rem_out = rem_w[N];
    assign quo_out = dat_w[N];

endmodule

### rtl/invertible_mod_prime_hash.sv
// Top level of the invertible modular hash: operand build, two modular chains, slot divider.
//
// Input channel s_*: one key per transfer. s_mode 0 hashes (s_item_id, s_parent_loc) into
// m_slot_out and m_quotient_out; s_mode 1 recovers m_item_out and m_parent_out from
// (s_home_addr, s_quotient_in). Unused result fields are zero.
// Configuration channel cfg_*: index 0 table size, 1 prime, 2 multiplier, 3 inverse;
// other indexes are ignored. Write only while no item is in flight.
// Throughput: one item per cycle while the receiver takes results. Structure: a 97-cell
// remainder row for the operand, a 128-cell row for the modular product and a 64-cell
// row dividing by the table size, plus five operand and output stages.
// Reset loads table size 2, prime 3, multiplier and inverse 1 and empties the pipeline.
// When the receiver stalls a finished result, the whole pipeline holds and s_ready
// drops until that result is taken.
module invertible_mod_prime_hash #(
    parameter int unsigned KEY_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [imh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imh_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [31:0]                    s_parent_loc,
    input  logic [31:0]                    s_item_id,
    input  logic [31:0]                    s_home_addr,
    input  logic [63:0]                    s_quotient_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_slot_out,
    output logic [63:0]                    m_quotient_out,
    output logic [63:0]                    m_item_out,
    output logic [31:0]                    m_parent_out
);

    localparam int unsigned TW = imh_pkg::TS_W;
    localparam int unsigned WW = imh_pkg::WORD_W;
    localparam int unsigned HW = imh_pkg::HALF_W;
    localparam int unsigned XW = imh_pkg::WIDE_W;
    localparam int unsigned PW = imh_pkg::PROD_W;

    logic [TW-1:0] ts_reg;
    logic [WW-1:0] prime_reg;
    logic [WW-1:0] mult_reg;
    logic [WW-1:0] inv_reg;

    logic ce;

    logic          s1_v_reg;
    logic          s1_mode_reg;
    logic [TW+HW-1:0] s1_plo_reg;
    logic [TW+HW-1:0] s1_phi_reg;
    logic [HW-1:0] s1_add_reg;

    logic          s2_v_reg;
    logic          s2_mode_reg;
    logic [XW-1:0] s2_x_reg;
    logic [XW-1:0] s2_sum;
    logic [WW-1:0] s2_key;

    logic          c1_v;
    logic          c1_mode;
    logic [WW-1:0] c1_rem;
    logic [XW-1:0] c1_quo;

    logic          s3_v_reg;
    logic          s3_mode_reg;
    logic [WW-1:0] s3_p00_reg;
    logic [WW-1:0] s3_p01_reg;
    logic [WW-1:0] s3_p10_reg;
    logic [WW-1:0] s3_p11_reg;
    logic [WW-1:0] s3_opa;

    logic          s4_v_reg;
    logic          s4_mode_reg;
    logic [PW-1:0] s4_prod_reg;

    logic          c2_v;
    logic          c2_mode;
    logic [WW-1:0] c2_rem;
    logic [PW-1:0] c2_quo;

    logic          c3_v;
    logic          c3_mode;
    logic [TW-1:0] c3_rem;
    logic [WW-1:0] c3_quo;

    logic          out_v_reg;
    logic [31:0]   slot_reg;
    logic [63:0]   quo_reg;
    logic [63:0]   item_reg;
    logic [31:0]   parent_reg;

    assign cfg_ready = 1'b1;
    assign ce        = !out_v_reg || m_ready;
    assign s_ready   = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg    <= TW'(2);
            prime_reg <= WW'(3);
            mult_reg  <= WW'(1);
            inv_reg   <= WW'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                imh_pkg::REG_TABLE_SIZE: ts_reg    <= cfg_wdata[TW-1:0];
                imh_pkg::REG_PRIME:      prime_reg <= cfg_wdata;
                imh_pkg::REG_MULTIPLIER: mult_reg  <= cfg_wdata;
                imh_pkg::REG_INVERSE:    inv_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else if (ce) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= c1_v;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_comb begin
        s2_sum = XW'(s1_plo_reg) + {s1_phi_reg, {HW{1'b0}}} + XW'(s1_add_reg);
        s2_key = WW'(s2_sum[KEY_BITS-1:0]);
        s3_opa = (c1_mode == imh_pkg::MODE_RECOVER) ? inv_reg : mult_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_mode_reg <= s_mode;
            if (s_mode == imh_pkg::MODE_RECOVER) begin
                s1_plo_reg <= s_quotient_in[HW-1:0] * ts_reg;
                s1_phi_reg <= s_quotient_in[WW-1:HW] * ts_reg;
                s1_add_reg <= s_home_addr;
            end else begin
                s1_plo_reg <= s_item_id * ts_reg;
                s1_phi_reg <= '0;
                s1_add_reg <= s_parent_loc;
            end
            s2_mode_reg <= s1_mode_reg;
            s2_x_reg    <= (s1_mode_reg == imh_pkg::MODE_RECOVER) ? s2_sum : XW'(s2_key);
            s3_mode_reg <= c1_mode;
            s3_p00_reg  <= s3_opa[HW-1:0]  * c1_rem[HW-1:0];
            s3_p01_reg  <= s3_opa[HW-1:0]  * c1_rem[WW-1:HW];
            s3_p10_reg  <= s3_opa[WW-1:HW] * c1_rem[HW-1:0];
            s3_p11_reg  <= s3_opa[WW-1:HW] * c1_rem[WW-1:HW];
            s4_mode_reg <= s3_mode_reg;
            s4_prod_reg <= PW'(s3_p00_reg) + {32'd0, s3_p01_reg, 32'd0}
                         + {32'd0, s3_p10_reg, 32'd0} + {s3_p11_reg, 64'd0};
        end
    end

    imh_div_chain #(.N(XW), .W(WW)) u_key_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .divisor  (prime_reg),
        .v_in     (s2_v_reg),
        .sb_in    (s2_mode_reg),
        .dividend (s2_x_reg),
        .v_out    (c1_v),
        .sb_out   (c1_mode),
        .rem_out  (c1_rem),
        .quo_out  (c1_quo)
    );

    imh_div_chain #(.N(PW), .W(WW)) u_prod_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .divisor  (prime_reg),
        .v_in     (s4_v_reg),
        .sb_in    (s4_mode_reg),
        .dividend (s4_prod_reg),
        .v_out    (c2_v),
        .sb_out   (c2_mode),
        .rem_out  (c2_rem),
        .quo_out  (c2_quo)
    );

    imh_div_chain #(.N(WW), .W(TW)) u_slot_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .divisor  (ts_reg),
        .v_in     (c2_v),
        .sb_in    (c2_mode),
        .dividend (c2_rem),
        .v_out    (c3_v),
        .sb_out   (c3_mode),
        .rem_out  (c3_rem),
        .quo_out  (c3_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (ce) begin
            out_v_reg <= c3_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (c3_mode == imh_pkg::MODE_RECOVER) begin
                slot_reg   <= '0;
                quo_reg    <= '0;
                item_reg   <= c3_quo;
                parent_reg <= c3_rem[31:0];
            end else begin
                slot_reg   <= c3_rem[31:0];
                quo_reg    <= c3_quo;
                item_reg   <= '0;
                parent_reg <= '0;
            end
        end
    end

    assign m_valid        = out_v_reg;
    assign m_slot_out     = slot_reg;
    assign m_quotient_out = quo_reg;
    assign m_item_out     = item_reg;
    assign m_parent_out   = parent_reg;

    // c1_quo and c2_quo feed only the quotient shift of the cells
    logic unused_quo;
    assign unused_quo = ^{c1_quo, c2_quo};

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_quotient_out) && $stable(m_item_out)))
        else $error("result changed while stalled");

    a_no_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline held");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item_out == '0 && m_parent_out == '0)
                     || (m_slot_out == '0 && m_quotient_out == '0)))
        else $error("both result groups non-zero");

endmodule

### bench/tb_invertible_mod_prime_hash.sv
// Self-checking testbench for the invertible modular hash: directed keys, then random traffic.
`timescale 1ns / 1ps

module tb_invertible_mod_prime_hash;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 320;
    localparam int unsigned RAND_PER_PHASE = 250;
    localparam int unsigned N_PHASES = 8;

    typedef struct packed {
        logic [31:0] slot;
        logic [63:0] quot;
        logic [63:0] item;
        logic [31:0] parent;
    } hash_res_t;

    typedef struct {
        logic        mode;
        logic [31:0] parent;
        logic [31:0] item;
        logic [31:0] home;
        logic [63:0] qin;
        bit          known;
        hash_res_t   res;
    } key_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [imh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [imh_pkg::WORD_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [31:0] s_parent_loc = '0;
    logic [31:0] s_item_id = '0;
    logic [31:0] s_home_addr = '0;
    logic [63:0] s_quotient_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_slot_out;
    logic [63:0] m_quotient_out;
    logic [63:0] m_item_out;
    logic [31:0] m_parent_out;

    logic [32:0] slots_m = 33'd2;
    logic [63:0] prime_p = 64'd3;
    logic [63:0] mult_a = 64'd1;
    logic [63:0] inv_a = 64'd1;

    hash_res_t expected_q[$];
    logic [31:0] seen_slot[$];
    logic [63:0] seen_quot[$];
    int unsigned snd_idle = 0;
    int unsigned rcv_stall = 0;
    int unsigned quiet_cycles = 0;
    bit failed = 1'b0;

    key_row_t dir_rows[14] = '{
        '{imh_pkg::MODE_HASH, 32'd0, 32'd0, 32'd0, 64'd0, 1'b1, '{32'd0, 64'd0, 64'd0, 32'd0}},
        '{imh_pkg::MODE_HASH, 32'd1, 32'd0, 32'd0, 64'd0, 1'b1, '{32'd1, 64'd0, 64'd0, 32'd0}},
        '{imh_pkg::MODE_HASH, 32'd0, 32'd1, 32'd0, 64'd0, 1'b1, '{32'd0, 64'd1, 64'd0, 32'd0}},
        '{imh_pkg::MODE_HASH, 32'd3, 32'd0, 32'd0, 64'd0, 1'b1, '{32'd0, 64'd0, 64'd0, 32'd0}},
        '{imh_pkg::MODE_RECOVER, 32'd0, 32'd0, 32'd0, 64'd0, 1'b1,
          '{32'd0, 64'd0, 64'd0, 32'd0}},
        '{imh_pkg::MODE_RECOVER, 32'd0, 32'd0, 32'd1, 64'd0, 1'b1,
          '{32'd0, 64'd0, 64'd0, 32'd1}},
        '{imh_pkg::MODE_RECOVER, 32'd0, 32'd0, 32'd0, 64'd1, 1'b1,
          '{32'd0, 64'd0, 64'd1, 32'd0}},
        '{imh_pkg::MODE_HASH, '1, '1, 32'd0, 64'd0, 1'b0, '0},
        '{imh_pkg::MODE_HASH, '1, 32'd0, '1, '1, 1'b0, '0},
        '{imh_pkg::MODE_HASH, 32'd0, '1, 32'd0, 64'd0, 1'b0, '0},
        '{imh_pkg::MODE_RECOVER, '1, '1, '1, '1, 1'b0, '0},
        '{imh_pkg::MODE_RECOVER, 32'd0, 32'd0, 32'd0, '1, 1'b0, '0},
        '{imh_pkg::MODE_RECOVER, 32'd0, 32'd0, '1, 64'd0, 1'b0, '0},
        '{imh_pkg::MODE_RECOVER, 32'd5, 32'd7, 32'h8000_0000, 64'h8000_0000_0000_0000,
          1'b0, '0}
    };

    invertible_mod_prime_hash dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] mod_prime(logic [127:0] w);
        return (prime_p == 0) ? w[63:0] : 64'(w % {64'd0, prime_p});
    endfunction

    function automatic hash_res_t hash_key(logic mode, logic [31:0] parent, logic [31:0] item,
                                           logic [31:0] home, logic [63:0] qin);
        hash_res_t res;
        logic [127:0] w;
        logic [63:0] v;
        res = '0;
        if (mode == imh_pkg::MODE_HASH) begin
            w = {96'd0, item} * {95'd0, slots_m} + {96'd0, parent};
            v = mod_prime({64'd0, mult_a} * {64'd0, w[63:0]});
            res.slot = (slots_m == 0) ? v[31:0] : 32'(v % {31'd0, slots_m});
            res.quot = (slots_m == 0) ? '1 : 64'(v / {31'd0, slots_m});
        end else begin
            w = {64'd0, qin} * {95'd0, slots_m} + {96'd0, home};
            v = mod_prime({64'd0, inv_a} * {64'd0, mod_prime(w)});
            res.parent = (slots_m == 0) ? v[31:0] : 32'(v % {31'd0, slots_m});
            res.item = (slots_m == 0) ? '1 : 64'(v / {31'd0, slots_m});
        end
        return res;
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(imh_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            imh_pkg::REG_TABLE_SIZE: slots_m = val[32:0];
            imh_pkg::REG_PRIME:      prime_p = val;
            imh_pkg::REG_MULTIPLIER: mult_a = val;
            imh_pkg::REG_INVERSE:    inv_a = val;
            default: ;
        endcase
    endtask

    task automatic send_key(key_row_t row);
        hash_res_t want;
        if ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < snd_idle);
        end
        s_valid <= 1'b1;
        s_mode <= row.mode;
        s_parent_loc <= row.parent;
        s_item_id <= row.item;
        s_home_addr <= row.home;
        s_quotient_in <= row.qin;
        do @(posedge aclk); while (!s_ready);
        want = row.known ? row.res : hash_key(row.mode, row.parent, row.item, row.home, row.qin);
        expected_q.push_back(want);
        if (row.mode == imh_pkg::MODE_HASH) begin
            seen_slot.push_back(want.slot);
            seen_quot.push_back(want.quot);
            if (seen_slot.size() > 64) begin
                void'(seen_slot.pop_front());
                void'(seen_quot.pop_front());
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge aclk) begin
        hash_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                failed = 1'b1;
            end else begin
                want = expected_q.pop_front();
                if (m_slot_out !== want.slot) begin
                    $error("slot_out: expected %0h, got %0h", want.slot, m_slot_out);
                    failed = 1'b1;
                end
                if (m_quotient_out !== want.quot) begin
                    $error("quotient_out: expected %0h, got %0h", want.quot, m_quotient_out);
                    failed = 1'b1;
                end
                if (m_item_out !== want.item) begin
                    $error("item_out: expected %0h, got %0h", want.item, m_item_out);
                    failed = 1'b1;
                end
                if (m_parent_out !== want.parent) begin
                    $error("parent_out: expected %0h, got %0h", want.parent, m_parent_out);
                    failed = 1'b1;
                end
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_invertible_mod_prime_hash: FAIL");
            $finish;
        end
    end

    initial begin
        key_row_t row;
        int k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) send_key(dir_rows[i]);
        drain();
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(imh_pkg::REG_TABLE_SIZE, 64'h1_0000_0000);
                    write_reg(imh_pkg::REG_PRIME, '1);
                    write_reg(imh_pkg::REG_MULTIPLIER, '1);
                    write_reg(imh_pkg::REG_INVERSE, '1);
                end
                2: begin
                    write_reg(imh_pkg::REG_TABLE_SIZE, 64'd0);
                    write_reg(imh_pkg::REG_PRIME, 64'd0);
                    write_reg(imh_pkg::REG_MULTIPLIER, {$urandom, $urandom});
                    write_reg(imh_pkg::REG_INVERSE, {$urandom, $urandom});
                end
                3: begin
                    write_reg(imh_pkg::REG_TABLE_SIZE, 64'($urandom_range(2, 65536)));
                    write_reg(imh_pkg::REG_PRIME, 64'h1FFF_FFFF_FFFF_FFFF);
                    write_reg(imh_pkg::REG_MULTIPLIER, 64'h1234_5678_9ABC_DEF1);
                    write_reg(imh_pkg::REG_INVERSE, {$urandom, $urandom});
                end
                4: begin
                    write_reg(imh_pkg::REG_TABLE_SIZE, 64'd3);
                    write_reg(imh_pkg::REG_PRIME, 64'($urandom_range(3, 1000)));
                    write_reg(imh_pkg::REG_MULTIPLIER, 64'($urandom_range(1, 100)));
                    write_reg(imh_pkg::REG_INVERSE, 64'($urandom_range(1, 100)));
                end
                7: begin
                    write_reg(imh_pkg::REG_TABLE_SIZE, 64'd2);
                    write_reg(imh_pkg::REG_PRIME, 64'd3);
                    write_reg(imh_pkg::REG_MULTIPLIER, 64'd1);
                    write_reg(imh_pkg::REG_INVERSE, 64'd1);
                end
                default: if (ph != 0) begin
                    write_reg(imh_pkg::REG_TABLE_SIZE,
                              {31'd0, 1'($urandom_range(1)), $urandom});
                    write_reg(imh_pkg::REG_PRIME, {$urandom, $urandom});
                    write_reg(imh_pkg::REG_MULTIPLIER, {$urandom, $urandom});
                    write_reg(imh_pkg::REG_INVERSE, {$urandom, $urandom});
                end
            endcase
            case (ph % 4)
                0: begin snd_idle = 0; rcv_stall = 0; end
                1: begin snd_idle = 84; rcv_stall = 0; end
                2: begin snd_idle = 0; rcv_stall = 84; end
                default: begin snd_idle = 26; rcv_stall = 26; end
            endcase
            seen_slot.delete();
            seen_quot.delete();
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                row.mode = 1'($urandom_range(1));
                row.parent = 32'(pick64());
                row.item = 32'(pick64());
                row.home = 32'(pick64());
                row.qin = pick64();
                row.known = 1'b0;
                row.res = '0;
                if (row.mode == imh_pkg::MODE_RECOVER && seen_slot.size() != 0
                        && $urandom_range(99) < 60) begin
                    k = int'($urandom_range(seen_slot.size() - 1));
                    row.home = seen_slot[k];
                    row.qin = seen_quot[k];
                end
                send_key(row);
            end
            drain();
        end
        if (!failed)
            $display("tb_invertible_mod_prime_hash: PASS");
        else
            $display("tb_invertible_mod_prime_hash: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/imh_pkg.sv
rtl/imh_div_cell.sv
rtl/imh_div_chain.sv
rtl/invertible_mod_prime_hash.sv
bench/tb_invertible_mod_prime_hash.sv
